// ===== sv/afm_pkg.sv =====
// Shared types, widths and register codes for the affine point and box mapper.
package afm_pkg;

    // Coordinate width of the input items and default fraction width of the coefficients.
    localparam int COORD_BITS    = 16;
    localparam int FRAC_BITS_DEF = 16;

    // Configuration port address width and register indexes.
    localparam int ADDR_BITS = 5;
    localparam int IDX_BITS  = 3;

    localparam logic [IDX_BITS-1:0] REG_COEF_A   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_COEF_B   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_COEF_C   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_COEF_D   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_OFFSET_X = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_OFFSET_Y = 3'd5;

    // Input item: a point, or a rectangle given by its top left corner and size.
    typedef struct packed {
        logic                         mode;
        logic signed [COORD_BITS-1:0] in_x;
        logic signed [COORD_BITS-1:0] in_y;
        logic        [COORD_BITS-2:0] in_width;
        logic        [COORD_BITS-2:0] in_height;
    } t_in_item;

    // Result item: a mapped point, or the enclosing integer box.
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic        [30:0] out_width;
        logic        [30:0] out_height;
    } t_out_item;

    // Transform coefficients as held by the register file.
    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_d;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
    } t_coefs;

endpackage

// ===== sv/afm_regs.sv =====
// Configuration register file holding the six transform coefficients.
module afm_regs #(
    parameter int FRAC_BITS = afm_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [afm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output afm_pkg::t_coefs              o_coefs
);
    import afm_pkg::*;

    localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;

    t_coefs               r_coefs;
    logic [IDX_BITS-1:0]  idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign idx     = paddr[ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_coefs = r_coefs;

    // Register writes; an index beyond the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.coef_a   <= ONE;
            r_coefs.coef_b   <= '0;
            r_coefs.coef_c   <= '0;
            r_coefs.coef_d   <= ONE;
            r_coefs.offset_x <= '0;
            r_coefs.offset_y <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_COEF_A:   r_coefs.coef_a   <= pwdata;
                REG_COEF_B:   r_coefs.coef_b   <= pwdata;
                REG_COEF_C:   r_coefs.coef_c   <= pwdata;
                REG_COEF_D:   r_coefs.coef_d   <= pwdata;
                REG_OFFSET_X: r_coefs.offset_x <= pwdata;
                REG_OFFSET_Y: r_coefs.offset_y <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // Read back of the addressed register.
    always_comb begin
        case (idx)
            REG_COEF_A:   prdata = r_coefs.coef_a;
            REG_COEF_B:   prdata = r_coefs.coef_b;
            REG_COEF_C:   prdata = r_coefs.coef_c;
            REG_COEF_D:   prdata = r_coefs.coef_d;
            REG_OFFSET_X: prdata = r_coefs.offset_x;
            REG_OFFSET_Y: prdata = r_coefs.offset_y;
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== sv/affine_point_and_box_map.sv =====
// Affine point and bounding box mapper: register file plus a five stage datapath.
// An input transfer is registered in stage one and moves on through stages two to four to the output register.
// Throughput is one item per cycle while the output is not stalled; the eight 32 by COORD_BITS multipliers in stage one
// and the three operand corner sums in stage three set the clock period.
// A stall holds each full stage; empty stages keep filling, so bubbles are squeezed out.
// Synchronous active low reset empties the pipeline and loads the identity transform.
module affine_point_and_box_map #(
    parameter int FRAC_BITS = afm_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  afm_pkg::t_in_item             i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output afm_pkg::t_out_item            o_data
);
    import afm_pkg::*;

    // Product, partial sum, full sum and integer widths.
    localparam int PW  = 32 + COORD_BITS;
    localparam int S2W = PW + 1;
    localparam int SW  = PW + 2;
    localparam int IW  = SW - FRAC_BITS;
    localparam int EW  = (IW > 33) ? IW : 33;
    localparam int DW  = EW + 1;

    localparam logic signed [SW-1:0] HALF     = SW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] CEIL_ADD = (SW'(1) << FRAC_BITS) - SW'(1);
    localparam logic signed [EW-1:0] S32_MAX  = $signed(EW'(33'h0_7FFF_FFFF));
    localparam logic signed [EW-1:0] S32_MIN  = -$signed(EW'(34'h0_8000_0000));
    localparam logic signed [DW-1:0] D31_MAX  = $signed(DW'(33'h0_7FFF_FFFF));

    t_coefs cf;

    afm_regs #(
        .FRAC_BITS(FRAC_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (cf)
    );

    logic signed [31:0] c_a, c_b, c_c, c_d, c_e, c_f;
    assign c_a = cf.coef_a;
    assign c_b = cf.coef_b;
    assign c_c = cf.coef_c;
    assign c_d = cf.coef_d;
    assign c_e = cf.offset_x;
    assign c_f = cf.offset_y;

    // Valid bits and flow control: a stage loads when it is empty or the next one moves.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5    = !r_v5 || !i_stall;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign o_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // Stage one: the corner terms. Size is forced to zero in point mode, so the low and
    // high corner sums both give the mapped point.
    logic signed [COORD_BITS-1:0] s0_x, s0_y, s0_w, s0_h;
    assign s0_x = i_data.in_x;
    assign s0_y = i_data.in_y;
    assign s0_w = i_data.mode ? $signed({1'b0, i_data.in_width})  : '0;
    assign s0_h = i_data.mode ? $signed({1'b0, i_data.in_height}) : '0;

    logic signed [PW-1:0] r_s1_ax, r_s1_aw, r_s1_cy, r_s1_ch;
    logic signed [PW-1:0] r_s1_bx, r_s1_bw, r_s1_dy, r_s1_dh;
    logic                 r_s1_mode;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_ax   <= c_a * s0_x;
            r_s1_aw   <= c_a * s0_w;
            r_s1_cy   <= c_c * s0_y;
            r_s1_ch   <= c_c * s0_h;
            r_s1_bx   <= c_b * s0_x;
            r_s1_bw   <= c_b * s0_w;
            r_s1_dy   <= c_d * s0_y;
            r_s1_dh   <= c_d * s0_h;
            r_s1_mode <= i_data.mode;
        end
    end

    // Stage two: per term, the extent along the size goes to the low or the high side
    // depending on the sign of its coefficient.
    logic signed [S2W-1:0] r_s2_lo_ax, r_s2_hi_ax, r_s2_lo_cy, r_s2_hi_cy;
    logic signed [S2W-1:0] r_s2_lo_bx, r_s2_hi_bx, r_s2_lo_dy, r_s2_hi_dy;
    logic                  r_s2_mode;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_lo_ax <= S2W'(r_s1_ax) + (c_a[31] ? S2W'(r_s1_aw) : S2W'(0));
            r_s2_hi_ax <= S2W'(r_s1_ax) + (c_a[31] ? S2W'(0) : S2W'(r_s1_aw));
            r_s2_lo_cy <= S2W'(r_s1_cy) + (c_c[31] ? S2W'(r_s1_ch) : S2W'(0));
            r_s2_hi_cy <= S2W'(r_s1_cy) + (c_c[31] ? S2W'(0) : S2W'(r_s1_ch));
            r_s2_lo_bx <= S2W'(r_s1_bx) + (c_b[31] ? S2W'(r_s1_bw) : S2W'(0));
            r_s2_hi_bx <= S2W'(r_s1_bx) + (c_b[31] ? S2W'(0) : S2W'(r_s1_bw));
            r_s2_lo_dy <= S2W'(r_s1_dy) + (c_d[31] ? S2W'(r_s1_dh) : S2W'(0));
            r_s2_hi_dy <= S2W'(r_s1_dy) + (c_d[31] ? S2W'(0) : S2W'(r_s1_dh));
            r_s2_mode  <= r_s1_mode;
        end
    end

    // Stage three: exact minimum and maximum over the four corners, with translation.
    logic signed [SW-1:0] r_s3_lo_x, r_s3_hi_x, r_s3_lo_y, r_s3_hi_y;
    logic                 r_s3_mode;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_lo_x <= SW'(r_s2_lo_ax) + SW'(r_s2_lo_cy) + SW'(c_e);
            r_s3_hi_x <= SW'(r_s2_hi_ax) + SW'(r_s2_hi_cy) + SW'(c_e);
            r_s3_lo_y <= SW'(r_s2_lo_bx) + SW'(r_s2_lo_dy) + SW'(c_f);
            r_s3_hi_y <= SW'(r_s2_hi_bx) + SW'(r_s2_hi_dy) + SW'(c_f);
            r_s3_mode <= r_s2_mode;
        end
    end

    // Stage four: round half up for a point, floor of the low and ceiling of the high
    // edge for a box.
    logic signed [SW-1:0] n_s4_lo_x, n_s4_lo_y, n_s4_hi_x, n_s4_hi_y;
    logic signed [SW-1:0] rnd;

    assign rnd       = r_s3_mode ? SW'(0) : HALF;
    assign n_s4_lo_x = r_s3_lo_x + rnd;
    assign n_s4_lo_y = r_s3_lo_y + rnd;
    assign n_s4_hi_x = r_s3_hi_x + CEIL_ADD;
    assign n_s4_hi_y = r_s3_hi_y + CEIL_ADD;

    logic signed [IW-1:0] r_s4_fx, r_s4_fy, r_s4_cx, r_s4_cy;
    logic                 r_s4_mode;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_fx   <= IW'(n_s4_lo_x >>> FRAC_BITS);
            r_s4_fy   <= IW'(n_s4_lo_y >>> FRAC_BITS);
            r_s4_cx   <= IW'(n_s4_hi_x >>> FRAC_BITS);
            r_s4_cy   <= IW'(n_s4_hi_y >>> FRAC_BITS);
            r_s4_mode <= r_s3_mode;
        end
    end

    // Stage five: saturation of the position and of the size taken from the raw edges.
    logic signed [EW-1:0] e_fx, e_fy;
    logic signed [DW-1:0] d_fx, d_fy, d_cx, d_cy, d_w, d_h;
    t_out_item            n_out;
    t_out_item            r_out;

    assign e_fx = EW'(r_s4_fx);
    assign e_fy = EW'(r_s4_fy);
    assign d_fx = DW'(r_s4_fx);
    assign d_fy = DW'(r_s4_fy);
    assign d_cx = DW'(r_s4_cx);
    assign d_cy = DW'(r_s4_cy);
    assign d_w  = d_cx - d_fx;
    assign d_h  = d_cy - d_fy;

    always_comb begin
        if (e_fx > S32_MAX)      n_out.out_x = 32'h7FFF_FFFF;
        else if (e_fx < S32_MIN) n_out.out_x = 32'h8000_0000;
        else                     n_out.out_x = e_fx[31:0];

        if (e_fy > S32_MAX)      n_out.out_y = 32'h7FFF_FFFF;
        else if (e_fy < S32_MIN) n_out.out_y = 32'h8000_0000;
        else                     n_out.out_y = e_fy[31:0];

        if (!r_s4_mode || d_w[DW-1]) n_out.out_width = '0;
        else if (d_w > D31_MAX)      n_out.out_width = 31'h7FFF_FFFF;
        else                         n_out.out_width = d_w[30:0];

        if (!r_s4_mode || d_h[DW-1]) n_out.out_height = '0;
        else if (d_h > D31_MAX)      n_out.out_height = 31'h7FFF_FFFF;
        else                         n_out.out_height = d_h[30:0];
    end

    logic r_s5_mode;

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_out     <= n_out;
            r_s5_mode <= r_s4_mode;
        end
    end

    assign o_data = r_out;

`ifndef SYNTHESIS
    // An input transfer always lands in stage one.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("input transfer did not reach stage one");

    // A full pipeline under output stall must push back on the input.
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_stall) |-> o_stall)
        else $error("full pipeline failed to stall the input");

    // The low corner sum never exceeds the high one.
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_s3_lo_x <= r_s3_hi_x) && (r_s3_lo_y <= r_s3_hi_y))
        else $error("corner minimum above maximum");

    // Point results carry no size.
    a_point_no_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_s5_mode) |-> (o_data.out_width == 31'd0) && (o_data.out_height == 31'd0))
        else $error("point result with non-zero size");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the affine point and box mapper.
module testbench;
    import afm_pkg::*;

    localparam int     FRAC         = FRAC_BITS_DEF;
    localparam int     ITEMS_PER_SET = 100;
    localparam int     RANDOM_SETS  = 8;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam longint S32_MIN      = -64'sd2147483648;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint FRAC_HALF    = 64'sd1 <<< (FRAC - 1);
    localparam longint FRAC_MASK    = (64'sd1 <<< FRAC) - 64'sd1;

    // Indexes past the last register; writes there must leave the transform alone.
    localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    // Scoreboard: holds the transform, predicts each accepted item and checks results in order.
    class box_map_scoreboard;
        t_coefs    coefs;
        t_out_item expected_q[$];
        int        mismatches;
        int        points;
        int        boxes;

        function new();
            coefs.coef_a   = 32'h0001_0000;
            coefs.coef_b   = '0;
            coefs.coef_c   = '0;
            coefs.coef_d   = 32'h0001_0000;
            coefs.offset_x = '0;
            coefs.offset_y = '0;
            mismatches     = 0;
            points         = 0;
            boxes          = 0;
        endfunction

        function void set_reg(logic [IDX_BITS-1:0] idx, logic [31:0] val);
            case (idx)
                REG_COEF_A:   coefs.coef_a   = val;
                REG_COEF_B:   coefs.coef_b   = val;
                REG_COEF_C:   coefs.coef_c   = val;
                REG_COEF_D:   coefs.coef_d   = val;
                REG_OFFSET_X: coefs.offset_x = val;
                REG_OFFSET_Y: coefs.offset_y = val;
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [IDX_BITS-1:0] idx);
            case (idx)
                REG_COEF_A:   return coefs.coef_a;
                REG_COEF_B:   return coefs.coef_b;
                REG_COEF_C:   return coefs.coef_c;
                REG_COEF_D:   return coefs.coef_d;
                REG_OFFSET_X: return coefs.offset_x;
                REG_OFFSET_Y: return coefs.offset_y;
                default:      return '0;
            endcase
        endfunction

        // Exact fixed-point sum p*u + q*v + t; it stays well inside 64 bits.
        function longint lin(longint p, longint q, longint t, longint u, longint v);
            return p * u + q * v + t;
        endfunction

        function longint sat32(longint v);
            if (v < S32_MIN) return S32_MIN;
            if (v > S32_MAX) return S32_MAX;
            return v;
        endfunction

        function longint sat31(longint v);
            if (v < 0) return 0;
            if (v > S32_MAX) return S32_MAX;
            return v;
        endfunction

        function void note_input(t_in_item it);
            longint    x, y, w, h, px, py;
            longint    minx, maxx, miny, maxy, fx, fy;
            longint    cx [4];
            longint    cy [4];
            t_out_item res;
            x = $signed(it.in_x);
            y = $signed(it.in_y);
            w = it.in_width;
            h = it.in_height;
            if (!it.mode) begin
                // Point: round to nearest, ties towards plus infinity.
                points++;
                px = lin(coefs.coef_a, coefs.coef_c, coefs.offset_x, x, y);
                py = lin(coefs.coef_b, coefs.coef_d, coefs.offset_y, x, y);
                res.out_x      = 32'(sat32((px + FRAC_HALF) >>> FRAC));
                res.out_y      = 32'(sat32((py + FRAC_HALF) >>> FRAC));
                res.out_width  = '0;
                res.out_height = '0;
            end else begin
                // Box: map all four corners, floor the minima and ceil the maxima.
                boxes++;
                cx[0] = x;     cy[0] = y;
                cx[1] = x + w; cy[1] = y;
                cx[2] = x + w; cy[2] = y + h;
                cx[3] = x;     cy[3] = y + h;
                for (int i = 0; i < 4; i++) begin
                    px = lin(coefs.coef_a, coefs.coef_c, coefs.offset_x, cx[i], cy[i]);
                    py = lin(coefs.coef_b, coefs.coef_d, coefs.offset_y, cx[i], cy[i]);
                    if (i == 0 || px < minx) minx = px;
                    if (i == 0 || px > maxx) maxx = px;
                    if (i == 0 || py < miny) miny = py;
                    if (i == 0 || py > maxy) maxy = py;
                end
                fx = minx >>> FRAC;
                fy = miny >>> FRAC;
                res.out_x      = 32'(sat32(fx));
                res.out_y      = 32'(sat32(fy));
                res.out_width  = 31'(sat31(((maxx + FRAC_MASK) >>> FRAC) - fx));
                res.out_height = 31'(sat31(((maxy + FRAC_MASK) >>> FRAC) - fy));
            end
            expected_q.push_back(res);
        endfunction

        function void field_cmp(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d w=%0d h=%0d", $time,
                         got.out_x, got.out_y, got.out_width, got.out_height);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            field_cmp("out_x", want.out_x, got.out_x);
            field_cmp("out_y", want.out_y, got.out_y);
            field_cmp("out_width", want.out_width, got.out_width);
            field_cmp("out_height", want.out_height, got.out_height);
        endfunction
    endclass

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_in_item             i_data  = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_out_item            o_data;

    box_map_scoreboard sb = new();
    bit     quiet      = 1'b0;
    int     stall_hold = 0;
    int     cycles     = 0;
    int     settings   = 0;
    int     reg_reads  = 0;

    affine_point_and_box_map u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic t_in_item make_item(bit mode, int x, int y, int w, int h);
        t_in_item it;
        it.mode      = mode;
        it.in_x      = COORD_BITS'(x);
        it.in_y      = COORD_BITS'(y);
        it.in_width  = (COORD_BITS-1)'(w);
        it.in_height = (COORD_BITS-1)'(h);
        return it;
    endfunction

    // Random item: a mix of full range and near-origin coordinates and small or full sizes.
    function automatic t_in_item rand_item();
        t_in_item it;
        it.mode = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0) begin
            it.in_x = COORD_BITS'($urandom);
            it.in_y = COORD_BITS'($urandom);
        end else begin
            it.in_x = COORD_BITS'($urandom_range(0, 1023) - 512);
            it.in_y = COORD_BITS'($urandom_range(0, 1023) - 512);
        end
        if ($urandom_range(0, 3) == 0) begin
            it.in_width  = (COORD_BITS-1)'($urandom);
            it.in_height = (COORD_BITS-1)'($urandom);
        end else begin
            it.in_width  = (COORD_BITS-1)'($urandom_range(0, 64));
            it.in_height = (COORD_BITS-1)'($urandom_range(0, 64));
        end
        return it;
    endfunction

    // Coefficient values: the extremes, zero, unit values, small fractions and full range.
    function automatic logic [31:0] rand_coef(bit unit_pos);
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return unit_pos ? 32'h0001_0000 : 32'hFFFF_0000;
            4, 5, 6: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
            default: return $urandom;
        endcase
    endfunction

    // Result side stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall    <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (i_stall) begin
            i_stall    <= 1'b0;
            stall_hold <= $urandom_range(0, 15);
        end else begin
            i_stall    <= ($urandom_range(0, 2) == 0);
            stall_hold <= pick_gap();
        end
    end

    // Every result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic apb_write(logic [IDX_BITS-1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(logic [IDX_BITS-1:0] idx);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        reg_reads++;
        if (got !== sb.reg_value(idx)) begin
            $display("%0t: register %0d expected %h, got %h", $time, idx,
                     sb.reg_value(idx), got);
            sb.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let every outstanding result drain before the registers are touched.
    task automatic wait_idle();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Load a full transform, optionally poke both spare indexes, then read all six registers back.
    task automatic set_transform(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 logic [31:0] d, logic [31:0] e, logic [31:0] f,
                                 bit spare);
        i_valid <= 1'b0;
        wait_idle();
        apb_write(REG_COEF_A, a);
        apb_write(REG_COEF_B, b);
        apb_write(REG_COEF_C, c);
        apb_write(REG_COEF_D, d);
        apb_write(REG_OFFSET_X, e);
        apb_write(REG_OFFSET_Y, f);
        if (spare) begin
            apb_write(REG_SPARE_LO, $urandom);
            apb_write(REG_SPARE_HI, $urandom);
        end
        for (int i = 0; i < 6; i++) apb_read_check(i[IDX_BITS-1:0]);
        settings++;
    endtask

    // One input transfer, with an optional idle gap carrying junk payload beforehand.
    task automatic send_item(t_in_item it);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) begin
                i_data <= rand_item();
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(it);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, then the identity transform on the coordinate extremes.
        for (int i = 0; i < 6; i++) apb_read_check(i[IDX_BITS-1:0]);
        send_item(make_item(1'b0, 0, 0, 32767, 32767));
        send_item(make_item(1'b0, -32768, -32768, 0, 0));
        send_item(make_item(1'b0, 32767, 32767, 32767, 32767));
        send_item(make_item(1'b1, -32768, -32768, 32767, 32767));
        send_item(make_item(1'b1, 32767, 32767, 32767, 32767));
        send_item(make_item(1'b1, 5, -7, 0, 0));

        // Half scale: exact ties in rounding, and fractional corners for floor and ceil.
        set_transform(32'h0000_8000, 0, 0, 32'h0000_8000, 0, 0, 1'b0);
        send_item(make_item(1'b0, 1, -1, 0, 0));
        send_item(make_item(1'b0, 3, -3, 0, 0));
        send_item(make_item(1'b1, -1, -1, 2, 3));
        send_item(make_item(1'b1, 1, 1, 1, 1));

        // Extreme coefficients and offsets: saturation in both directions and of the size.
        set_transform(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_item(make_item(1'b0, 32767, -32768, 0, 0));
        send_item(make_item(1'b0, -32768, 32767, 0, 0));
        send_item(make_item(1'b0, 0, 0, 0, 0));
        send_item(make_item(1'b1, -32768, -32768, 32767, 32767));
        send_item(make_item(1'b1, 0, 0, 1, 1));

        // Quarter turn with translation: the box minimum comes from other corners.
        set_transform(0, 32'h0001_0000, 32'hFFFF_0000, 0, 32'h0003_4000, 32'hFFFD_C000,
                      1'b0);
        send_item(make_item(1'b0, 10, 20, 0, 0));
        send_item(make_item(1'b1, -3, 4, 9, 2));

        // Mirror in both axes; spare indexes written as well and must be ignored.
        set_transform(32'hFFFF_0000, 0, 0, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_7FFF,
                      1'b1);
        send_item(make_item(1'b0, 7, -7, 0, 0));
        send_item(make_item(1'b1, -100, 50, 200, 25));
        send_item(make_item(1'b1, 32767, -32768, 32767, 32767));

        // Random part: a fresh transform for every set, one set without any idling.
        for (int s = 0; s < RANDOM_SETS; s++) begin
            set_transform(rand_coef(1'b1), rand_coef(1'b0), rand_coef(1'b0),
                          rand_coef(1'b1), rand_coef(1'b0), rand_coef(1'b0),
                          $urandom_range(0, 3) == 0);
            quiet = (s == 2);
            for (int n = 0; n < ITEMS_PER_SET; n++) send_item(rand_item());
            quiet = 1'b0;
        end
        i_valid <= 1'b0;
        wait_idle();

        $display("covered %0d points and %0d boxes over %0d transform settings,",
                 sb.points, sb.boxes, settings + 1);
        $display("with %0d register reads checked and result stalls on both sides",
                 reg_reads);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/afm_pkg.sv
sv/afm_regs.sv
sv/affine_point_and_box_map.sv
tb/testbench.sv
